/* hw/rtl/cgpw_pkg.sv */
package cgpw_pkg;

	localparam int CFG_W       = 12;
	localparam int COORD_W     = 13;
	localparam int COLOR_W     = 32;
	localparam int ADDR_W      = 22;
	localparam int GLYPH_SIZE  = 8;
	localparam int GLYPH_BITS  = GLYPH_SIZE * GLYPH_SIZE;
	localparam int GLYPH_IDX_W = $clog2(GLYPH_BITS);
	localparam int GLYPH_RC_W  = $clog2(GLYPH_SIZE);

	localparam int MAX_WIDTH_DEF   = 2048;
	localparam int MAX_HEIGHT_DEF  = 2048;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_GLYPH = 1'b1;

	// one clipped request handed from front to back
	typedef struct packed {
		logic [GLYPH_BITS-1:0] mask;
		logic [ADDR_W-1:0]     base;
		logic [CFG_W-1:0]      width;
		logic [COLOR_W-1:0]    color;
	} cmd_t;

endpackage

/* hw/rtl/clipped_glyph_and_pixel_writer.sv */
// Turns pixel and 8x8 glyph draw requests into clipped framebuffer writes, one
// result per on-screen pixel, in glyph bit order, with last_write on the final
// write of each request; requests with nothing on screen produce no result.
// A request passes through the front-end registers s1 and s2 (clip mask and
// row-base multiply), then waits in a small queue; the back end emits one
// write per cycle while its output register is free or being popped, so a
// glyph with n visible set bits (up to 64) takes n writes, and a pixel request
// one. Sustained rate is set by that emitter. Configuration writes are always
// ready and must only be issued while idle.
module clipped_glyph_and_pixel_writer
	import cgpw_pkg::*;
#(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      op,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [COLOR_W-1:0]        pixel_color,
	input  logic [GLYPH_BITS-1:0]     glyph_bits,
	output logic                      empty,
	input  logic                      pop,
	output logic [ADDR_W-1:0]         write_address,
	output logic [COLOR_W-1:0]        write_color,
	output logic                      last_write,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data
);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cmd_t q_wdata;
	cmd_t q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cgpw_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.op            (op),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pixel_color   (pixel_color),
		.glyph_bits    (glyph_bits),
		.screen_width  (width_q),
		.screen_height (height_q),
		.q_push        (q_push),
		.q_data        (q_wdata),
		.q_full        (q_full)
	);

	cgpw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.valid     (q_valid)
	);

	cgpw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.write_address (write_address),
		.write_color   (write_color),
		.last_write    (last_write)
	);

endmodule

/* hw/rtl/cgpw_front.sv */
module cgpw_front
	import cgpw_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      op,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [COLOR_W-1:0]        pixel_color,
	input  logic [GLYPH_BITS-1:0]     glyph_bits,
	input  logic [CFG_W-1:0]          screen_width,
	input  logic [CFG_W-1:0]          screen_height,
	output logic                      q_push,
	output cmd_t                      q_data,
	input  logic                      q_full
);

	logic                      valid_s1;
	logic                      op_s1;
	logic [COORD_W-1:0]        x_s1;
	logic [COORD_W-1:0]        y_s1;
	logic [COLOR_W-1:0]        color_s1;
	logic [GLYPH_BITS-1:0]     bits_s1;

	logic                      valid_s2;
	logic [GLYPH_BITS-1:0]     mask_s2;
	logic [ADDR_W-1:0]         prod_s2;
	logic [COORD_W-1:0]        x_s2;
	logic [CFG_W-1:0]          w_s2;
	logic [COLOR_W-1:0]        color_s2;

	logic [CFG_W-1:0]          w_eff;
	logic [CFG_W-1:0]          h_eff;
	logic [GLYPH_SIZE-1:0]     col_ok;
	logic [GLYPH_SIZE-1:0]     row_ok;
	logic [GLYPH_BITS-1:0]     draw_bits;
	logic [GLYPH_BITS-1:0]     mask_d;
	logic signed [2*COORD_W-1:0] prod_d;
	logic signed [COORD_W:0]   col_d [GLYPH_SIZE];
	logic signed [COORD_W:0]   row_d [GLYPH_SIZE];

	logic                      s2_live;
	logic                      s2_stall;
	logic                      s1_adv;
	logic                      accept;

	assign w_eff = (32'(screen_width) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : screen_width;
	assign h_eff = (32'(screen_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : screen_height;

	always_comb begin
		for (int i = 0; i < GLYPH_SIZE; i++) begin
			col_d[i]  = $signed({x_s1[COORD_W-1], x_s1}) + $signed((COORD_W+1)'(i));
			row_d[i]  = $signed({y_s1[COORD_W-1], y_s1}) + $signed((COORD_W+1)'(i));
			col_ok[i] = !col_d[i][COORD_W] && (col_d[i][COORD_W-1:0] < {1'b0, w_eff});
			row_ok[i] = !row_d[i][COORD_W] && (row_d[i][COORD_W-1:0] < {1'b0, h_eff});
		end
		draw_bits = (op_s1 == OP_GLYPH) ? bits_s1 : GLYPH_BITS'(1);
		for (int k = 0; k < GLYPH_BITS; k++) begin
			mask_d[k] = draw_bits[k] & col_ok[k % GLYPH_SIZE] & row_ok[k / GLYPH_SIZE];
		end
	end

	assign prod_d = $signed({1'b0, w_eff}) * $signed(y_s1);

	assign s2_live  = |mask_s2;
	assign s2_stall = valid_s2 && s2_live && q_full;
	assign s1_adv   = valid_s1 && !s2_stall;
	assign full     = valid_s1 && s2_stall;
	assign accept   = push && !full;
	assign q_push   = valid_s2 && s2_live && !q_full;

	assign q_data.mask  = mask_s2;
	assign q_data.base  = prod_s2 + ADDR_W'($signed(x_s2));
	assign q_data.width = w_s2;
	assign q_data.color = color_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (s1_adv)
				valid_s1 <= 1'b0;
			if (s1_adv)
				valid_s2 <= 1'b1;
			else if (!s2_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			x_s1     <= pos_x;
			y_s1     <= pos_y;
			color_s1 <= pixel_color;
			bits_s1  <= glyph_bits;
		end
		if (s1_adv) begin
			mask_s2  <= mask_d;
			prod_s2  <= prod_d[ADDR_W-1:0];
			x_s2     <= x_s1;
			w_s2     <= w_eff;
			color_s2 <= color_s1;
		end
	end

endmodule

/* hw/rtl/cgpw_queue.sv */
module cgpw_queue
	import cgpw_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNT_W'(DEPTH)) || pop)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue pop while empty");

endmodule

/* hw/rtl/cgpw_back.sv */
module cgpw_back
	import cgpw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cmd_t              q_data,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output logic [ADDR_W-1:0] write_address,
	output logic [COLOR_W-1:0] write_color,
	output logic              last_write
);

	logic                  cur_valid_q;
	logic [GLYPH_BITS-1:0] cur_mask_q;
	logic [ADDR_W-1:0]     cur_base_q;
	logic [CFG_W-1:0]      cur_width_q;
	logic [COLOR_W-1:0]    cur_color_q;

	logic                  out_valid_q;
	logic [ADDR_W-1:0]     out_addr_q;
	logic [COLOR_W-1:0]    out_color_q;
	logic                  out_last_q;

	logic                   out_free;
	logic                   step;
	logic [GLYPH_IDX_W-1:0] idx;
	logic [GLYPH_RC_W-1:0]  row;
	logic [GLYPH_RC_W-1:0]  col;
	logic [GLYPH_BITS-1:0]  rest_mask;
	logic                   done;
	logic [ADDR_W-1:0]      addr_d;

	always_comb begin
		idx = '0;
		for (int i = GLYPH_BITS - 1; i >= 0; i--) begin
			if (cur_mask_q[i])
				idx = GLYPH_IDX_W'(i);
		end
	end

	assign row       = idx[GLYPH_IDX_W-1:GLYPH_RC_W];
	assign col       = idx[GLYPH_RC_W-1:0];
	assign rest_mask = cur_mask_q & (cur_mask_q - 1'b1);
	assign done      = (rest_mask == '0);
	assign addr_d    = cur_base_q + ADDR_W'(cur_width_q) * ADDR_W'(row) + ADDR_W'(col);

	assign out_free = !out_valid_q || pop;
	assign step     = cur_valid_q && out_free;
	assign q_pop    = q_valid && (!cur_valid_q || (step && done));

	assign empty         = !out_valid_q;
	assign write_address = out_addr_q;
	assign write_color   = out_color_q;
	assign last_write    = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop)
				cur_valid_q <= 1'b1;
			else if (step && done)
				cur_valid_q <= 1'b0;
			if (step)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_mask_q  <= q_data.mask;
			cur_base_q  <= q_data.base;
			cur_width_q <= q_data.width;
			cur_color_q <= q_data.color;
		end else if (step) begin
			cur_mask_q <= rest_mask;
		end
		if (step) begin
			out_addr_q  <= addr_d;
			out_color_q <= cur_color_q;
			out_last_q  <= done;
		end
	end

	a_cur_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> cur_mask_q != '0)
		else $error("active request with no pixels left");

	a_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_last_q == $past(done))
		else $error("last_write out of step with remaining mask");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !cur_valid_q || (step && done))
		else $error("request loaded over unfinished one");

endmodule
